// ===== rtl/khp_pkg.sv =====
// ----------------------------------------------------------------------------
// khp_pkg: shared types, constants and helpers of the keyed binary heap
// Sizes of the heap levels, entry and command formats, and the index
// arithmetic that maps a heap position onto a level and an offset.
// ----------------------------------------------------------------------------
package khp_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int ENTRY_W  = KEY_W + VAL_W;
  localparam int ST_W     = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LEVELS   = CNT_W;
  localparam int IDX_W    = LEVELS + 1;
  localparam int OFF_W    = (LEVELS > 2) ? LEVELS - 1 : 2;
  localparam int LVL_W    = $clog2(LEVELS);
  localparam int SCAN_N   = ((1 << (LEVELS - 2)) > (CAPACITY - (1 << (LEVELS - 1)) + 1)) ?
                            (1 << (LEVELS - 2)) : (CAPACITY - (1 << (LEVELS - 1)) + 1);

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_E    = 2'd0,
    SRC_UP   = 2'd1,
    SRC_DN_A = 2'd2,
    SRC_DN_B = 2'd3
  } wr_src_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
  } entry_t;

  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [OFF_W-1:0] off;
  } pos_t;

  typedef struct packed {
    logic                    clr;
    logic                    scan;
    logic [OFF_W-1:0]        scan_off;
    logic signed [KEY_W-1:0] key;
    logic [CNT_W-1:0]        count;
    logic                    rd_en;
    logic [LVL_W-1:0]        rd_lvl;
    logic [OFF_W-1:0]        rd_off_a;
    logic [OFF_W-1:0]        rd_off_b;
    logic                    wr_en;
    logic [LVL_W-1:0]        wr_lvl;
    logic [OFF_W-1:0]        wr_off;
    wr_src_t                 wr_src;
    entry_t                  entry;
  } cmd_t;

  typedef struct packed {
    logic             hit;
    logic [OFF_W-1:0] off;
  } hit_t;

  function automatic int level_depth(input int l);
    int full;
    int rest;
    full = 1 << l;
    rest = CAPACITY - full + 1;
    return (rest < full) ? rest : full;
  endfunction

  function automatic int addr_w(input int d);
    return (d > 1) ? $clog2(d) : 1;
  endfunction

  function automatic logic [IDX_W-1:0] glob(input logic [LVL_W-1:0] lvl,
                                            input logic [OFF_W-1:0] off);
    return (IDX_W'(1) << lvl) - IDX_W'(1) + IDX_W'(off);
  endfunction

  function automatic pos_t pos_of(input logic [CNT_W-1:0] idx);
    logic [IDX_W-1:0] n;
    pos_t             p;
    n = IDX_W'(idx) + IDX_W'(1);
    p = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (n[i]) begin
        p.lvl = LVL_W'(i);
      end
    end
    p.off = OFF_W'(n - (IDX_W'(1) << p.lvl));
    return p;
  endfunction

  function automatic logic outranks(input logic mode,
                                    input logic signed [KEY_W-1:0] a,
                                    input logic signed [KEY_W-1:0] b);
    return mode ? (a > b) : (a < b);
  endfunction

endpackage

// ===== rtl/khp_in_if.sv =====
// ----------------------------------------------------------------------------
// khp_in_if: request channel of the keyed binary heap
// Carries one add or remove request with its key and payload.
// ----------------------------------------------------------------------------
interface khp_in_if;
  import khp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [KEY_W-1:0] key;
  logic [VAL_W-1:0]        value;

  modport source (output valid, command, key, value, input ready);
  modport sink   (input valid, command, key, value, output ready);
endinterface

// ===== rtl/khp_out_if.sv =====
// ----------------------------------------------------------------------------
// khp_out_if: result channel of the keyed binary heap
// Carries the status, fill count and root entry after each request.
// ----------------------------------------------------------------------------
interface khp_out_if;
  import khp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic [CNT_W-1:0]        count;
  logic                    heap_empty;
  logic signed [KEY_W-1:0] top_key;
  logic [VAL_W-1:0]        top_value;

  modport source (output valid, status, count, heap_empty, top_key, top_value, input ready);
  modport sink   (input valid, status, count, heap_empty, top_key, top_value, output ready);
endinterface

// ===== rtl/keyed_binary_heap.sv =====
// ----------------------------------------------------------------------------
// keyed_binary_heap: priority queue of unique signed keys with payloads
// Top level: a row of heap level cells, each with its own storage, under
// one request sequencer.
// ----------------------------------------------------------------------------
// Requests are handled one at a time and each returns exactly one result.
// Every request first scans all levels of the heap in parallel for its key,
// one slot per cycle, over as many slots as the widest level holds (32 at a
// capacity of 64), followed by a wait for the last match and the decision.
// An add then sifts the new entry up one level at a time; a remove that
// does not hit the last entry fetches that entry and sifts it up or down
// one level at a time. A new request is taken while the previous result
// still waits at the output. The heap order follows cfg_wdata, which
// should only be changed between requests: 0 keeps the smallest key on top,
// 1 the largest. Held entries are not reordered when the order changes.
// ----------------------------------------------------------------------------
module keyed_binary_heap (
  input  logic      clk,
  input  logic      rst_n,
  khp_in_if.sink    in_ch,
  khp_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import khp_pkg::*;

  cmd_t             cmd;
  hit_t             hits    [LEVELS];
  entry_t           rd_a    [LEVELS];
  entry_t           rd_b    [LEVELS];
  entry_t           wdata   [LEVELS];
  logic [OFF_W-1:0] waddr   [LEVELS];
  logic [OFF_W-1:0] raddr_a [LEVELS];
  logic [OFF_W-1:0] raddr_b [LEVELS];
  logic [LEVELS-1:0] we;
  logic [LEVELS-1:0] hit_vec;

  khp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .hits       (hits),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .root_we    (we[0]),
    .root_wdata (wdata[0])
  );

  for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
    localparam int DEPTH = level_depth(g);
    localparam int AW    = addr_w(DEPTH);

    entry_t up_rd;
    entry_t dn_rd_a;
    entry_t dn_rd_b;

    if (g == 0) begin : g_top
      assign up_rd = '0;
    end else begin : g_mid
      assign up_rd = rd_a[g-1];
    end

    if (g == LEVELS - 1) begin : g_leaf
      assign dn_rd_a = '0;
      assign dn_rd_b = '0;
    end else begin : g_inner
      assign dn_rd_a = rd_a[g+1];
      assign dn_rd_b = rd_b[g+1];
    end

    khp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .level   (LVL_W'(g)),
      .cmd     (cmd),
      .rd_a    (rd_a[g]),
      .up_rd   (up_rd),
      .dn_rd_a (dn_rd_a),
      .dn_rd_b (dn_rd_b),
      .we      (we[g]),
      .waddr   (waddr[g]),
      .wdata   (wdata[g]),
      .raddr_a (raddr_a[g]),
      .raddr_b (raddr_b[g]),
      .hit     (hits[g])
    );

    khp_ram #(
      .DEPTH (DEPTH),
      .WIDTH (ENTRY_W)
    ) u_ram (
      .clk     (clk),
      .we      (we[g]),
      .waddr   (waddr[g][AW-1:0]),
      .wdata   (wdata[g]),
      .raddr_a (raddr_a[g][AW-1:0]),
      .raddr_b (raddr_b[g][AW-1:0]),
      .rdata_a (rd_a[g]),
      .rdata_b (rd_b[g])
    );

    assign hit_vec[g] = hits[g].hit;
  end

  // Keys are unique, so the scan can find the key at one level at most.
  a_single_hit : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(hit_vec) <= 1)
    else $error("key found at more than one heap level");

  a_single_write : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(we))
    else $error("more than one heap level written in one cycle");

  a_one_request : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("new request taken while one is in progress");

  a_empty_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.heap_empty == (out_ch.count == '0)))
    else $error("empty flag disagrees with the fill count");

endmodule

// ===== rtl/khp_ram.sv =====
// ----------------------------------------------------------------------------
// khp_ram: generic storage with one write port and two read ports
// Read data is registered; each read port returns the word addressed in
// the previous cycle.
// ----------------------------------------------------------------------------
module khp_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/khp_cell.sv =====
// ----------------------------------------------------------------------------
// khp_cell: one level of the heap
// Drives the storage of its level, searches it for the request key during
// the scan, and takes write data from the sequencer or from a neighbouring level.
// ----------------------------------------------------------------------------
module khp_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [khp_pkg::LVL_W-1:0] level,
  input  khp_pkg::cmd_t             cmd,
  input  khp_pkg::entry_t           rd_a,
  input  khp_pkg::entry_t           up_rd,
  input  khp_pkg::entry_t           dn_rd_a,
  input  khp_pkg::entry_t           dn_rd_b,
  output logic                      we,
  output logic [khp_pkg::OFF_W-1:0] waddr,
  output khp_pkg::entry_t           wdata,
  output logic [khp_pkg::OFF_W-1:0] raddr_a,
  output logic [khp_pkg::OFF_W-1:0] raddr_b,
  output khp_pkg::hit_t             hit
);
  import khp_pkg::*;

  logic             sel;
  logic             scan_d_r;
  logic [OFF_W-1:0] off_d_r;
  logic             hit_r;
  logic [OFF_W-1:0] hit_off_r;
  logic             entry_vld;
  logic             match;

  always_comb begin
    sel     = cmd.rd_en && (cmd.rd_lvl == level);
    raddr_a = cmd.scan ? cmd.scan_off : (sel ? cmd.rd_off_a : '0);
    raddr_b = sel ? cmd.rd_off_b : '0;
    we      = cmd.wr_en && (cmd.wr_lvl == level);
    waddr   = cmd.wr_off;
    case (cmd.wr_src)
      SRC_E:    wdata = cmd.entry;
      SRC_UP:   wdata = up_rd;
      SRC_DN_A: wdata = dn_rd_a;
      SRC_DN_B: wdata = dn_rd_b;
      default:  wdata = cmd.entry;
    endcase
  end

  // An offset only names a real slot if it lies inside this level and below
  // the fill count.
  assign entry_vld = ((off_d_r >> level) == '0) &&
                     (glob(level, off_d_r) < IDX_W'(cmd.count));
  assign match     = scan_d_r && entry_vld && (rd_a.key == cmd.key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_d_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      scan_d_r <= cmd.scan;
      if (cmd.clr) begin
        hit_r <= 1'b0;
      end else if (match) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    off_d_r <= cmd.scan_off;
    if (match) begin
      hit_off_r <= off_d_r;
    end
  end

  assign hit.hit = hit_r;
  assign hit.off = hit_off_r;

endmodule

// ===== rtl/khp_ctrl.sv =====
// ----------------------------------------------------------------------------
// khp_ctrl: request sequencer of the keyed binary heap
// Runs the key scan over all levels, decides the outcome, moves entries up
// or down between neighbouring levels and registers the result.
// ----------------------------------------------------------------------------
module khp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  khp_in_if.sink          in_ch,
  khp_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  output khp_pkg::cmd_t   cmd,
  input  khp_pkg::hit_t   hits [khp_pkg::LEVELS],
  input  khp_pkg::entry_t rd_a [khp_pkg::LEVELS],
  input  khp_pkg::entry_t rd_b [khp_pkg::LEVELS],
  input  logic            root_we,
  input  khp_pkg::entry_t root_wdata
);
  import khp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_SCAN      = 11'b000_0000_0010,
    S_SCAN_WAIT = 11'b000_0000_0100,
    S_DECIDE    = 11'b000_0000_1000,
    S_LAST_RD   = 11'b000_0001_0000,
    S_LAST_CAP  = 11'b000_0010_0000,
    S_UP_RD     = 11'b000_0100_0000,
    S_UP_CMP    = 11'b000_1000_0000,
    S_DN_RD     = 11'b001_0000_0000,
    S_DN_CMP    = 11'b010_0000_0000,
    S_DONE      = 11'b100_0000_0000
  } state_t;

  localparam logic [OFF_W-1:0] SCAN_LAST = OFF_W'(SCAN_N - 1);
  localparam logic [LVL_W-1:0] LVL_LAST  = LVL_W'(LEVELS - 1);

  state_t                  state_r, state_nxt;
  logic                    mode_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [LVL_W-1:0]        cur_lvl_r, cur_lvl_nxt;
  logic [OFF_W-1:0]        cur_off_r, cur_off_nxt;
  logic                    first_r, first_nxt;
  entry_t                  e_r, e_nxt;
  logic [OFF_W-1:0]        scan_off_r, scan_off_nxt;
  status_t                 status_r, status_nxt;
  logic                    req_cmd_r;
  logic signed [KEY_W-1:0] req_key_r;
  logic [VAL_W-1:0]        req_val_r;
  entry_t                  top_r;
  logic                    out_vld_r;
  status_t                 out_status_r;
  logic [CNT_W-1:0]        out_count_r;
  logic                    out_empty_r;
  entry_t                  out_top_r;
  logic                    accept;
  logic                    out_load;

  always_comb begin
    logic             any_hit;
    logic [LVL_W-1:0] hit_lvl;
    logic [OFF_W-1:0] hit_off;
    pos_t             new_pos;
    pos_t             last_pos;
    logic [CNT_W-1:0] cnt_dec;
    logic [LVL_W-1:0] up_lvl;
    logic [LVL_W-1:0] dn_lvl;
    logic [IDX_W-1:0] child_l;
    logic             l_vld;
    logic             r_vld;
    entry_t           parent;
    entry_t           best;
    wr_src_t          pick;

    any_hit = 1'b0;
    hit_lvl = '0;
    hit_off = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (hits[i].hit) begin
        any_hit = 1'b1;
        hit_lvl = LVL_W'(i);
        hit_off = hits[i].off;
      end
    end
    new_pos  = pos_of(count_r);
    last_pos = pos_of(count_r);
    cnt_dec  = count_r - CNT_W'(1);
    up_lvl   = cur_lvl_r - LVL_W'(1);
    dn_lvl   = (cur_lvl_r == LVL_LAST) ? cur_lvl_r : cur_lvl_r + LVL_W'(1);
    child_l  = (glob(cur_lvl_r, cur_off_r) << 1) + IDX_W'(1);
    l_vld    = child_l < IDX_W'(count_r);
    r_vld    = (child_l + IDX_W'(1)) < IDX_W'(count_r);
    parent   = rd_a[up_lvl];

    best = e_r;
    pick = SRC_E;
    if (l_vld && outranks(mode_r, rd_a[dn_lvl].key, best.key)) begin
      best = rd_a[dn_lvl];
      pick = SRC_DN_A;
    end
    if (r_vld && outranks(mode_r, rd_b[dn_lvl].key, best.key)) begin
      pick = SRC_DN_B;
    end

    state_nxt    = state_r;
    count_nxt    = count_r;
    cur_lvl_nxt  = cur_lvl_r;
    cur_off_nxt  = cur_off_r;
    first_nxt    = first_r;
    e_nxt        = e_r;
    scan_off_nxt = scan_off_r;
    status_nxt   = status_r;

    cmd          = '0;
    cmd.scan_off = scan_off_r;
    cmd.key      = req_key_r;
    cmd.count    = count_r;
    cmd.entry    = e_r;
    cmd.wr_lvl   = cur_lvl_r;
    cmd.wr_off   = cur_off_r;
    cmd.wr_src   = SRC_E;

    case (state_r)
      S_IDLE: begin
        cmd.clr = 1'b1;
        if (in_ch.valid) begin
          scan_off_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan     = 1'b1;
        scan_off_nxt = scan_off_r + OFF_W'(1);
        if (scan_off_r == SCAN_LAST) begin
          state_nxt = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        status_nxt = ST_OK;
        if (req_cmd_r == CMD_ADD) begin
          if (any_hit) begin
            status_nxt = ST_DUP;
            state_nxt  = S_DONE;
          end else if (count_r == CNT_W'(CAPACITY)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            cur_lvl_nxt = new_pos.lvl;
            cur_off_nxt = new_pos.off;
            e_nxt       = '{key: req_key_r, value: req_val_r};
            count_nxt   = count_r + CNT_W'(1);
            first_nxt   = 1'b0;
            state_nxt   = S_UP_RD;
          end
        end else begin
          if (!any_hit) begin
            status_nxt = ST_MISS;
            state_nxt  = S_DONE;
          end else begin
            count_nxt   = cnt_dec;
            cur_lvl_nxt = hit_lvl;
            cur_off_nxt = hit_off;
            if (glob(hit_lvl, hit_off) == IDX_W'(cnt_dec)) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_LAST_RD;
            end
          end
        end
      end
      S_LAST_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_lvl   = last_pos.lvl;
        cmd.rd_off_a = last_pos.off;
        state_nxt    = S_LAST_CAP;
      end
      S_LAST_CAP: begin
        e_nxt     = rd_a[last_pos.lvl];
        first_nxt = 1'b1;
        state_nxt = S_UP_RD;
      end
      S_UP_RD: begin
        if (cur_lvl_r == '0) begin
          if (first_r) begin
            first_nxt = 1'b0;
            state_nxt = S_DN_RD;
          end else begin
            cmd.wr_en = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_lvl   = up_lvl;
          cmd.rd_off_a = cur_off_r >> 1;
          state_nxt    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (outranks(mode_r, e_r.key, parent.key)) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_src  = SRC_UP;
          cur_lvl_nxt = up_lvl;
          cur_off_nxt = cur_off_r >> 1;
          first_nxt   = 1'b0;
          state_nxt   = S_UP_RD;
        end else if (first_r) begin
          first_nxt = 1'b0;
          state_nxt = S_DN_RD;
        end else begin
          cmd.wr_en = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DN_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_lvl   = dn_lvl;
        cmd.rd_off_a = {cur_off_r[OFF_W-2:0], 1'b0};
        cmd.rd_off_b = {cur_off_r[OFF_W-2:0], 1'b1};
        state_nxt    = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = pick;
        if (pick == SRC_E) begin
          state_nxt = S_DONE;
        end else begin
          cur_lvl_nxt = dn_lvl;
          cur_off_nxt = {cur_off_r[OFF_W-2:0], (pick == SRC_DN_B)};
          state_nxt   = S_DN_RD;
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      mode_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_lvl_r  <= cur_lvl_nxt;
    cur_off_r  <= cur_off_nxt;
    first_r    <= first_nxt;
    e_r        <= e_nxt;
    scan_off_r <= scan_off_nxt;
    status_r   <= status_nxt;
    if (accept) begin
      req_cmd_r <= in_ch.command;
      req_key_r <= in_ch.key;
      req_val_r <= in_ch.value;
    end
    if (root_we) begin
      top_r <= root_wdata;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_count_r  <= count_r;
      out_empty_r  <= (count_r == '0);
      out_top_r    <= (count_r == '0) ? '0 : top_r;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.heap_empty = out_empty_r;
  assign out_ch.top_key    = out_top_r.key;
  assign out_ch.top_value  = out_top_r.value;

endmodule
